// ===== src/i2cras_pkg.sv =====
`timescale 1ns / 1ps

package i2cras_pkg;

    // Opcodes of an input word
    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_DONE  = 2'd2;
    localparam logic [1:0] OP_TICK  = 2'd3;

    // Commands issued to the byte engine
    localparam logic [2:0] CMD_NONE   = 3'd0;
    localparam logic [2:0] CMD_START  = 3'd1;
    localparam logic [2:0] CMD_RSTART = 3'd2;
    localparam logic [2:0] CMD_SEND   = 3'd3;
    localparam logic [2:0] CMD_RECV   = 3'd4;
    localparam logic [2:0] CMD_NACK   = 3'd5;
    localparam logic [2:0] CMD_STOP   = 3'd6;

    // Sequencer phases
    localparam logic [3:0] PH_IDLE   = 4'd0;
    localparam logic [3:0] PH_START  = 4'd1;
    localparam logic [3:0] PH_ADDR_W = 4'd2;
    localparam logic [3:0] PH_REG    = 4'd3;
    localparam logic [3:0] PH_DATA   = 4'd4;
    localparam logic [3:0] PH_RSTART = 4'd5;
    localparam logic [3:0] PH_ADDR_R = 4'd6;
    localparam logic [3:0] PH_RECV   = 4'd7;
    localparam logic [3:0] PH_NACK   = 4'd8;
    localparam logic [3:0] PH_STOP   = 4'd9;

    // Transaction outcomes
    localparam logic [1:0] FAIL_NONE    = 2'd0;
    localparam logic [1:0] FAIL_NACK    = 2'd1;
    localparam logic [1:0] FAIL_TIMEOUT = 2'd2;

    localparam logic [15:0] RECEIVE_TIMEOUT_RESET = 16'd10000;

    typedef struct packed {
        logic [1:0] opcode;
        logic [6:0] device_address;
        logic [7:0] register_index;
        logic [7:0] write_value;
        logic       nack_seen;
        logic [7:0] received_byte;
    } in_word_t;

    typedef struct packed {
        logic [2:0] command;
        logic [7:0] command_byte;
        logic       finished;
        logic [7:0] read_result;
        logic [1:0] outcome;
    } out_word_t;

    typedef struct packed {
        logic [3:0]  phase;
        logic        is_read;
        logic [6:0]  held_address;
        logic [7:0]  held_register;
        logic [7:0]  held_data;
        logic [15:0] wait_count;
        logic [7:0]  captured_byte;
        logic [1:0]  failure_kind;
    } seq_state_t;

endpackage

// ===== src/i2cras_step.sv =====
`timescale 1ns / 1ps

// Next-state and result logic for one input word
module i2cras_step
    import i2cras_pkg::*;
(
    input  seq_state_t  state_cur,
    input  in_word_t    word_in,
    input  logic [15:0] receive_timeout,
    output seq_state_t  state_next,
    output out_word_t   word_out
);

    always_comb begin
        state_next = state_cur;
        word_out   = '0;

        if (state_cur.phase == PH_IDLE || state_cur.phase > PH_STOP) begin
            // idle: latch a new request
            state_next.phase = PH_IDLE;
            if (word_in.opcode == OP_READ || word_in.opcode == OP_WRITE) begin
                state_next.is_read       = (word_in.opcode == OP_READ);
                state_next.held_address  = word_in.device_address;
                state_next.held_register = word_in.register_index;
                state_next.held_data     = word_in.write_value;
                state_next.captured_byte = '0;
                state_next.failure_kind  = FAIL_NONE;
                state_next.wait_count    = '0;
                state_next.phase         = PH_START;
                word_out.command         = CMD_START;
            end
        end else if (word_in.opcode == OP_TICK) begin
            // timeout countdown only while waiting for the received byte
            if (state_cur.phase == PH_RECV) begin
                if (state_cur.wait_count <= 16'd1) begin
                    state_next.wait_count   = '0;
                    state_next.failure_kind = FAIL_TIMEOUT;
                    state_next.phase        = PH_STOP;
                    word_out.command        = CMD_STOP;
                end else begin
                    state_next.wait_count = state_cur.wait_count - 16'd1;
                end
            end
        end else if (word_in.opcode == OP_DONE) begin
            unique case (state_cur.phase)
                PH_START: begin
                    word_out.command      = CMD_SEND;
                    word_out.command_byte = {state_cur.held_address, 1'b0};
                    state_next.phase      = PH_ADDR_W;
                end
                PH_ADDR_W: begin
                    if (word_in.nack_seen) begin
                        state_next.failure_kind = FAIL_NACK;
                        state_next.phase        = PH_STOP;
                        word_out.command        = CMD_STOP;
                    end else begin
                        word_out.command      = CMD_SEND;
                        word_out.command_byte = state_cur.held_register;
                        state_next.phase      = PH_REG;
                    end
                end
                PH_REG: begin
                    if (word_in.nack_seen) begin
                        state_next.failure_kind = FAIL_NACK;
                        state_next.phase        = PH_STOP;
                        word_out.command        = CMD_STOP;
                    end else if (state_cur.is_read) begin
                        word_out.command = CMD_RSTART;
                        state_next.phase = PH_RSTART;
                    end else begin
                        word_out.command      = CMD_SEND;
                        word_out.command_byte = state_cur.held_data;
                        state_next.phase      = PH_DATA;
                    end
                end
                PH_DATA: begin
                    state_next.failure_kind = word_in.nack_seen ? FAIL_NACK : FAIL_NONE;
                    state_next.phase        = PH_STOP;
                    word_out.command        = CMD_STOP;
                end
                PH_RSTART: begin
                    word_out.command      = CMD_SEND;
                    word_out.command_byte = {state_cur.held_address, 1'b1};
                    state_next.phase      = PH_ADDR_R;
                end
                PH_ADDR_R: begin
                    if (word_in.nack_seen) begin
                        state_next.failure_kind = FAIL_NACK;
                        state_next.phase        = PH_STOP;
                        word_out.command        = CMD_STOP;
                    end else begin
                        word_out.command      = CMD_RECV;
                        state_next.wait_count = receive_timeout;
                        state_next.phase      = PH_RECV;
                    end
                end
                PH_RECV: begin
                    // byte arrived: capture it even on the last tick count
                    state_next.captured_byte = word_in.received_byte;
                    word_out.command         = CMD_NACK;
                    state_next.phase         = PH_NACK;
                end
                PH_NACK: begin
                    state_next.failure_kind = FAIL_NONE;
                    state_next.phase        = PH_STOP;
                    word_out.command        = CMD_STOP;
                end
                default: begin
                    // stop done: report the transaction
                    word_out.finished = 1'b1;
                    word_out.outcome  = state_cur.failure_kind;
                    if (state_cur.is_read && state_cur.failure_kind == FAIL_NONE) begin
                        word_out.read_result = state_cur.captured_byte;
                    end
                    state_next.phase = PH_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== src/i2c_register_access_sequencer_core.sv =====
`timescale 1ns / 1ps

// Channel   Ports                        Direction  Word
// input     s_valid, s_ready, s_word     in         in_word_t (opcode, address, data, status)
// result    m_valid, m_ready, m_word     out        out_word_t (command, completion)
// config    cfg_we, cfg_wdata            in         receive_timeout, 16 bits
//
// Each input word gives exactly one result word: the word sits in the input register and passes
// through the step logic into the result register. Throughput is one word per cycle while the
// result register is not stalled; the sequencer state updates as a word leaves the input register.
// aresetn is synchronous, active low; it returns the sequencer to idle and the timeout to 10000.
// A stalled result register holds the input register, and s_ready drops only when both are full.

module i2c_register_access_sequencer_core
    import i2cras_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  in_word_t    s_word,

    output logic        m_valid,
    input  logic        m_ready,
    output out_word_t   m_word,

    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata
);

    logic        in_valid_reg;
    in_word_t    in_word_reg;
    logic        out_valid_reg;
    out_word_t   out_word_reg;
    seq_state_t  state_reg;
    seq_state_t  state_next;
    out_word_t   out_word_next;
    logic [15:0] timeout_reg;
    logic        out_free;
    logic        advance;

    // pipeline flow control
    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || advance;
    assign m_valid  = out_valid_reg;
    assign m_word   = out_word_reg;

    i2cras_step u_step (
        .state_cur       (state_reg),
        .word_in         (in_word_reg),
        .receive_timeout (timeout_reg),
        .state_next      (state_next),
        .word_out        (out_word_next)
    );

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            in_word_reg <= s_word;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
        if (advance) begin
            out_word_reg <= out_word_next;
        end
    end

    // sequencer state; all-zero is idle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // timeout register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= RECEIVE_TIMEOUT_RESET;
        end else if (cfg_we) begin
            timeout_reg <= cfg_wdata;
        end
    end

    // checks
    a_phase_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.phase <= PH_STOP)
        else $error("sequencer phase out of range");

    a_finished_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_word.finished |-> m_word.command == CMD_NONE)
        else $error("completion word carries a command");

    a_outcome_with_finished: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_word.outcome != FAIL_NONE |-> m_word.finished)
        else $error("outcome reported without completion");

    a_ready_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> in_valid_reg && out_valid_reg && !m_ready)
        else $error("input stalled with room in the pipeline");

endmodule

// ===== bench/i2c_sequencer_checker.sv =====
`timescale 1ns / 1ps

module i2c_sequencer_checker
    import i2cras_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    input  logic        s_ready,
    input  in_word_t    s_word,

    input  logic        m_valid,
    input  logic        m_ready,
    input  out_word_t   m_word,

    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,

    output int          mismatches,
    output int          pending,
    output int          reads_ok,
    output int          writes_ok,
    output int          nacked,
    output int          timed_out
);

    localparam int PRINT_CAP = 40;

    // Shadow copy of the sequencer and its timeout register
    seq_state_t  seq_st;
    logic [15:0] rx_timeout;
    out_word_t   cmd_expect_q[$];

    task automatic report_mismatch(input string msg);
        if (mismatches < PRINT_CAP) begin
            $display("checker @%0t: %s", $time, msg);
        end
        mismatches++;
    endtask

    function automatic logic [2:0] enter_stop(input logic [1:0] kind);
        seq_st.failure_kind = kind;
        seq_st.phase = PH_STOP;
        return CMD_STOP;
    endfunction

    // Advance the shadow sequencer by one input word; returns the command word it issues
    function automatic out_word_t sequencer_step(input in_word_t w);
        out_word_t r;
        r = '0;
        r.command = CMD_NONE;
        if (seq_st.phase == PH_IDLE || seq_st.phase > PH_STOP) begin
            seq_st.phase = PH_IDLE;
            if (w.opcode == OP_READ || w.opcode == OP_WRITE) begin
                seq_st.is_read       = (w.opcode == OP_READ);
                seq_st.held_address  = w.device_address;
                seq_st.held_register = w.register_index;
                seq_st.held_data     = w.write_value;
                seq_st.captured_byte = '0;
                seq_st.failure_kind  = FAIL_NONE;
                seq_st.wait_count    = '0;
                seq_st.phase         = PH_START;
                r.command            = CMD_START;
            end
        end else if (w.opcode == OP_TICK) begin
            // ticks only matter while waiting for the received byte
            if (seq_st.phase == PH_RECV) begin
                if (seq_st.wait_count <= 16'd1) begin
                    seq_st.wait_count = '0;
                    r.command = enter_stop(FAIL_TIMEOUT);
                end else begin
                    seq_st.wait_count = seq_st.wait_count - 16'd1;
                end
            end
        end else if (w.opcode == OP_DONE) begin
            case (seq_st.phase)
                PH_START: begin
                    r.command      = CMD_SEND;
                    r.command_byte = {seq_st.held_address, 1'b0};
                    seq_st.phase   = PH_ADDR_W;
                end
                PH_ADDR_W: begin
                    if (w.nack_seen) begin
                        r.command = enter_stop(FAIL_NACK);
                    end else begin
                        r.command      = CMD_SEND;
                        r.command_byte = seq_st.held_register;
                        seq_st.phase   = PH_REG;
                    end
                end
                PH_REG: begin
                    if (w.nack_seen) begin
                        r.command = enter_stop(FAIL_NACK);
                    end else if (seq_st.is_read) begin
                        r.command    = CMD_RSTART;
                        seq_st.phase = PH_RSTART;
                    end else begin
                        r.command      = CMD_SEND;
                        r.command_byte = seq_st.held_data;
                        seq_st.phase   = PH_DATA;
                    end
                end
                PH_DATA: begin
                    r.command = enter_stop(w.nack_seen ? FAIL_NACK : FAIL_NONE);
                end
                PH_RSTART: begin
                    r.command      = CMD_SEND;
                    r.command_byte = {seq_st.held_address, 1'b1};
                    seq_st.phase   = PH_ADDR_R;
                end
                PH_ADDR_R: begin
                    if (w.nack_seen) begin
                        r.command = enter_stop(FAIL_NACK);
                    end else begin
                        r.command         = CMD_RECV;
                        seq_st.wait_count = rx_timeout;
                        seq_st.phase      = PH_RECV;
                    end
                end
                PH_RECV: begin
                    // byte arrives even on the last tick count value
                    seq_st.captured_byte = w.received_byte;
                    r.command            = CMD_NACK;
                    seq_st.phase         = PH_NACK;
                end
                PH_NACK: begin
                    r.command = enter_stop(FAIL_NONE);
                end
                default: begin
                    // stop done: report the transaction
                    r.finished = 1'b1;
                    r.outcome  = seq_st.failure_kind;
                    if (seq_st.is_read && seq_st.failure_kind == FAIL_NONE) begin
                        r.read_result = seq_st.captured_byte;
                    end
                    seq_st.phase = PH_IDLE;
                end
            endcase
        end
        return r;
    endfunction

    // Sample both channels at the clock edge; results first, then new words
    always @(posedge aclk) begin
        out_word_t want;
        if (!aresetn) begin
            seq_st = '0;
            seq_st.phase = PH_IDLE;
            rx_timeout = RECEIVE_TIMEOUT_RESET;
            cmd_expect_q.delete();
        end else begin
            if (cfg_we) begin
                rx_timeout = cfg_wdata;
            end
            if (m_valid && m_ready) begin
                if (cmd_expect_q.size() == 0) begin
                    report_mismatch($sformatf("result word with nothing expected: %h", m_word));
                end else begin
                    want = cmd_expect_q.pop_front();
                    if (m_word.command !== want.command)
                        report_mismatch($sformatf("command got %0d want %0d",
                                                  m_word.command, want.command));
                    if (m_word.command_byte !== want.command_byte)
                        report_mismatch($sformatf("command_byte got %h want %h",
                                                  m_word.command_byte, want.command_byte));
                    if (m_word.finished !== want.finished)
                        report_mismatch($sformatf("finished got %b want %b",
                                                  m_word.finished, want.finished));
                    if (m_word.read_result !== want.read_result)
                        report_mismatch($sformatf("read_result got %h want %h",
                                                  m_word.read_result, want.read_result));
                    if (m_word.outcome !== want.outcome)
                        report_mismatch($sformatf("outcome got %0d want %0d",
                                                  m_word.outcome, want.outcome));
                end
            end
            if (s_valid && s_ready) begin
                want = sequencer_step(s_word);
                cmd_expect_q.push_back(want);
                if (want.finished) begin
                    case (want.outcome)
                        FAIL_NACK:    nacked++;
                        FAIL_TIMEOUT: timed_out++;
                        default: begin
                            if (seq_st.is_read) reads_ok++;
                            else writes_ok++;
                        end
                    endcase
                end
            end
        end
        pending = cmd_expect_q.size();
    end

endmodule

// ===== bench/tb_i2c_register_access_sequencer_core.sv =====
`timescale 1ns / 1ps

module tb_i2c_register_access_sequencer_core;
    import i2cras_pkg::*;

    localparam int CYCLE_LIMIT     = 400000;
    localparam int WORK_TARGET     = 1260;
    localparam int NUM_SETTINGS    = 9;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES    = 8;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    in_word_t    s_word;
    logic        m_valid;
    logic        m_ready;
    out_word_t   m_word;
    logic        cfg_we;
    logic [15:0] cfg_wdata;

    int mismatches, pending, reads_ok, writes_ok, nacked, timed_out;
    int cycle_count;
    int work_words;
    int total_words;

    logic [15:0] cur_timeout;
    bit          src_gaps;
    bit          quiet_tail;
    bit          hold_request;

    // One planned word of a transaction
    typedef struct {
        logic [1:0] op;
        logic       nack;
        bit         waiting;   // block may sit in the receive wait before this word
        bit         counted;
    } plan_step_t;

    plan_step_t step_plan[$];

    i2c_register_access_sequencer_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_word    (s_word),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_word    (m_word),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    i2c_sequencer_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_word     (s_word),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_word     (m_word),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .mismatches (mismatches),
        .pending    (pending),
        .reads_ok   (reads_ok),
        .writes_ok  (writes_ok),
        .nacked     (nacked),
        .timed_out  (timed_out)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic in_word_t word_of(input logic [1:0] op, input logic [6:0] addr,
                                         input logic [7:0] regi, input logic [7:0] data,
                                         input logic nack, input logic [7:0] rx);
        in_word_t w;
        w.opcode         = op;
        w.device_address = addr;
        w.register_index = regi;
        w.write_value    = data;
        w.nack_seen      = nack;
        w.received_byte  = rx;
        return w;
    endfunction

    function automatic in_word_t random_word(input logic [1:0] op);
        return word_of(op, 7'($urandom), 8'($urandom), 8'($urandom),
                       1'($urandom), 8'($urandom));
    endfunction

    function automatic void add_step(input logic [1:0] op, input logic nack,
                                     input bit waiting, input bit counted);
        step_plan.push_back('{op, nack, waiting, counted});
    endfunction

    // Offer one word and hold it until accepted; random gaps before it
    task automatic push_word(input in_word_t w, input bit counted);
        if (src_gaps && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_word  <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        total_words++;
        if (counted) work_words++;
    endtask

    task automatic wait_for_drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    // Plan one register access, optionally cut short and recovered, then send it
    task automatic run_transaction(input bit broken);
        bit       rd;
        bit       failed;
        int       eff;
        int       ticks;
        int       keep;
        int       k;
        in_word_t w;
        step_plan.delete();
        rd = 1'($urandom_range(0, 1));
        add_step(rd ? OP_READ : OP_WRITE, 1'($urandom), 0, 1);
        add_step(OP_DONE, 1'($urandom), 0, 1);            // start done, nack bit ignored
        failed = ($urandom_range(0, 9) == 0);
        add_step(OP_DONE, failed, 0, 1);                   // address + write bit
        if (!failed) begin
            failed = ($urandom_range(0, 9) == 0);
            add_step(OP_DONE, failed, 0, 1);               // register byte
        end
        if (!failed && !rd) begin
            add_step(OP_DONE, 1'($urandom), 0, 1);         // data byte, stop either way
        end
        if (!failed && rd) begin
            add_step(OP_DONE, 1'($urandom), 0, 1);         // repeated start
            failed = ($urandom_range(0, 9) == 0);
            add_step(OP_DONE, failed, 0, 1);               // address + read bit
            if (!failed) begin
                // the tick that times out is number max(timeout, 1)
                eff = (cur_timeout <= 16'd1) ? 1 : int'(cur_timeout);
                ticks = (cur_timeout <= 16'd8) ? $urandom_range(0, eff + 2)
                                                : $urandom_range(0, 4);
                for (k = 0; k < ticks; k++) begin
                    add_step(OP_TICK, 1'($urandom), k < eff, k < eff);
                end
                if (ticks < eff) begin
                    add_step(OP_DONE, 1'($urandom), 1, 1); // byte received
                    add_step(OP_DONE, 1'($urandom), 0, 1); // nack sent
                end
            end
        end
        add_step(OP_DONE, 1'($urandom), 0, 1);             // stop done

        // broken: cut before the stop, one stray word, then nacked dones back to idle
        if (broken) begin
            keep = $urandom_range(1, step_plan.size() - 1);
            while (step_plan.size() > keep) void'(step_plan.pop_back());
            add_step(2'($urandom), 1'($urandom), 1, 0);
            repeat (4) add_step(OP_DONE, 1'b1, 1, 0);
        end

        foreach (step_plan[i]) begin
            // noise that the block ignores: stray done/tick while idle, request/tick while busy
            if (!step_plan[i].waiting && $urandom_range(0, 11) == 0) begin
                if (i == 0)
                    w = random_word($urandom_range(0, 1) ? OP_DONE : OP_TICK);
                else if ($urandom_range(0, 2) == 0)
                    w = random_word(OP_TICK);
                else
                    w = random_word($urandom_range(0, 1) ? OP_READ : OP_WRITE);
                push_word(w, 0);
            end
            w = random_word(step_plan[i].op);
            w.nack_seen = step_plan[i].nack;
            push_word(w, step_plan[i].counted);
        end
    endtask

    // Result side: random stalls, one long hold-off on request, always ready at the end
    initial begin
        m_ready <= 1'b0;
        @(posedge aclk);
        forever begin
            if (quiet_tail) begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end else if (hold_request) begin
                hold_request = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
            end else begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge aclk);
                m_ready <= 1'b1;
                repeat (($urandom_range(0, 3) == 0) ? $urandom_range(100, 250)
                                                   : $urandom_range(1, 30)) @(posedge aclk);
            end
        end
    end

    // Stimulus
    initial begin
        logic [15:0] settings [NUM_SETTINGS];
        int          ph;
        int          goal;
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_word    <= '0;
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        cur_timeout = RECEIVE_TIMEOUT_RESET;
        src_gaps = 1'b1;
        settings = '{16'd65535, 16'd1, 16'd0, 16'd3, 16'd10000, 16'd2, 16'd6,
                     16'($urandom_range(1, 65535)), 16'd4};
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: ignored words, a full write at max fields, a full read at min fields,
        // a write nacked on the address
        push_word(word_of(OP_DONE, 7'h00, 8'h00, 8'h00, 1'b1, 8'hff), 0);
        push_word(word_of(OP_TICK, 7'h7f, 8'hff, 8'hff, 1'b1, 8'hff), 0);
        push_word(word_of(OP_WRITE, 7'h7f, 8'hff, 8'hff, 1'b0, 8'h00), 1);
        push_word(word_of(OP_DONE, 7'h00, 8'h00, 8'h00, 1'b1, 8'h00), 1);
        push_word(word_of(OP_READ, 7'h00, 8'h00, 8'h00, 1'b0, 8'h00), 0);
        push_word(word_of(OP_DONE, 7'h00, 8'h00, 8'h00, 1'b0, 8'h00), 1);
        push_word(word_of(OP_TICK, 7'h00, 8'h00, 8'h00, 1'b0, 8'h00), 0);
        push_word(word_of(OP_DONE, 7'h00, 8'h00, 8'h00, 1'b0, 8'h00), 1);
        push_word(word_of(OP_DONE, 7'h00, 8'h00, 8'h00, 1'b0, 8'h00), 1);
        push_word(word_of(OP_DONE, 7'h00, 8'h00, 8'h00, 1'b0, 8'h00), 1);
        push_word(word_of(OP_READ, 7'h00, 8'h00, 8'hff, 1'b1, 8'hff), 1);
        push_word(word_of(OP_DONE, 7'h7f, 8'hff, 8'hff, 1'b0, 8'h00), 1);
        push_word(word_of(OP_DONE, 7'h7f, 8'hff, 8'hff, 1'b0, 8'h00), 1);
        push_word(word_of(OP_DONE, 7'h7f, 8'hff, 8'hff, 1'b0, 8'h00), 1);
        push_word(word_of(OP_DONE, 7'h7f, 8'hff, 8'hff, 1'b1, 8'h00), 1);
        push_word(word_of(OP_DONE, 7'h7f, 8'hff, 8'hff, 1'b0, 8'h00), 1);
        push_word(word_of(OP_TICK, 7'h7f, 8'hff, 8'hff, 1'b1, 8'h00), 1);
        push_word(word_of(OP_DONE, 7'h00, 8'h00, 8'h00, 1'b1, 8'hff), 1);
        push_word(word_of(OP_DONE, 7'h00, 8'h00, 8'h00, 1'b0, 8'h00), 1);
        push_word(word_of(OP_DONE, 7'h00, 8'h00, 8'h00, 1'b0, 8'h00), 1);
        push_word(word_of(OP_WRITE, 7'h55, 8'h00, 8'h00, 1'b0, 8'h00), 1);
        push_word(word_of(OP_DONE, 7'h00, 8'h00, 8'h00, 1'b0, 8'h00), 1);
        push_word(word_of(OP_DONE, 7'h00, 8'h00, 8'h00, 1'b1, 8'h00), 1);
        push_word(word_of(OP_DONE, 7'h00, 8'h00, 8'h00, 1'b0, 8'h00), 1);

        // Random phases, one timeout setting each; the last one runs without idling
        for (ph = 0; ph < NUM_SETTINGS; ph++) begin
            wait_for_drain();
            cfg_we    <= 1'b1;
            cfg_wdata <= settings[ph];
            cur_timeout = settings[ph];
            @(posedge aclk);
            cfg_we <= 1'b0;
            quiet_tail = (ph == NUM_SETTINGS - 1);
            if (ph == 2) hold_request = 1'b1;
            goal = work_words + WORK_TARGET / NUM_SETTINGS;
            while (work_words < goal) begin
                src_gaps = !quiet_tail && ph != 2 && ($urandom_range(0, 2) != 0);
                run_transaction($urandom_range(0, 9) == 0);
            end
        end

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d input words (%0d in transaction sequences), timeouts 0, 1 and 65535",
                 total_words, work_words);
        $display("transactions: %0d reads ok, %0d writes ok, %0d slave nacks, %0d receive timeouts",
                 reads_ok, writes_ok, nacked, timed_out);
        if (mismatches == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
